// ----- hw/rtl/dtq_pkg.sv -----
package dtq_pkg;

    localparam int QueueDepthDef = 32;
    localparam int TimeBitsDef   = 48;
    localparam int IdBitsDef     = 16;
    localparam int ReleaseLimit  = 32;

    localparam logic [2:0] OP_SCHEDULE   = 3'd0;
    localparam logic [2:0] OP_CANCEL_ID  = 3'd1;
    localparam logic [2:0] OP_CANCEL_GRP = 3'd2;
    localparam logic [2:0] OP_CANCEL_ALL = 3'd3;
    localparam logic [2:0] OP_ALARM      = 3'd4;

    localparam logic [2:0] KIND_SCHEDULED = 3'd0;
    localparam logic [2:0] KIND_REJ_INF   = 3'd1;
    localparam logic [2:0] KIND_REJ_FULL  = 3'd2;
    localparam logic [2:0] KIND_RELEASED  = 3'd3;
    localparam logic [2:0] KIND_DONE      = 3'd4;

    localparam logic [1:0] TA_LEAVE   = 2'd0;
    localparam logic [1:0] TA_RESTART = 2'd1;
    localparam logic [1:0] TA_STOP    = 2'd2;

    localparam logic [31:0] DelayInfinite = 32'hFFFF_FFFF;
    localparam logic [31:0] TimerMax      = 32'hFFFF_FFFE;

    // classified command handed from front to back
    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] job;
        logic [15:0] grp;
        logic [31:0] delay;
        logic [63:0] now;
    } t_cmd;

endpackage

// ----- hw/rtl/deadline_timer_queue_top.sv -----
// Deadline-ordered timer queue.
// Each command is answered after a sweep of all entries, one entry a cycle;
// cancel by id or group takes a second sweep to find the new earliest.
// A new command is taken only once the back end is idle and its last beat has gone;
// an alarm releases one beat per sweep, rescanning after each release.
// Reset (synchronous, active low) empties the queue and clears the order counter.
module deadline_timer_queue_top
    import dtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDef,
    parameter int TIME_BITS   = TimeBitsDef,
    parameter int ID_BITS     = IdBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [15:0] i_job_id,
    input  logic [15:0] i_group_id,
    input  logic [31:0] i_delay,
    input  logic [47:0] i_now,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [15:0] o_out_job_id,
    output logic [15:0] o_out_group_id,
    output logic [1:0]  o_timer_action,
    output logic [31:0] o_timer_value,
    output logic        o_last
);

    logic w_cv, w_cr;
    t_cmd w_cmd;

    dtq_front #(.TIME_BITS(TIME_BITS), .ID_BITS(ID_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_operation, .i_job_id,
        .i_group_id, .i_delay, .i_now,
        .o_cmd_valid(w_cv), .i_cmd_ready(w_cr), .o_cmd(w_cmd)
    );

    dtq_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .TIME_BITS(TIME_BITS)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(w_cv), .o_cmd_ready(w_cr), .i_cmd(w_cmd),
        .o_valid, .i_ready, .o_kind, .o_out_job_id, .o_out_group_id,
        .o_timer_action, .o_timer_value, .o_last
    );

    a_rel_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_RELEASED |-> !o_last) else $error("release beat marked last");
    a_stop_cancel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_timer_action == TA_STOP |-> o_kind == KIND_DONE)
        else $error("timer stop outside done beat");
    a_val_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_timer_action != TA_RESTART |-> o_timer_value == 32'd0)
        else $error("timer value without restart");

endmodule

// ----- hw/rtl/dtq_front.sv -----
module dtq_front
    import dtq_pkg::*;
#(
    parameter int TIME_BITS = TimeBitsDef,
    parameter int ID_BITS   = IdBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [15:0] i_job_id,
    input  logic [15:0] i_group_id,
    input  logic [31:0] i_delay,
    input  logic [47:0] i_now,
    output logic        o_cmd_valid,
    input  logic        i_cmd_ready,
    output t_cmd        o_cmd
);

    localparam logic [63:0] TMask = (TIME_BITS >= 64) ? '1 : ((64'd1 << TIME_BITS) - 64'd1);

    // two-entry queue between front and back
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_c;
    logic [63:0] w_now;
    logic [15:0] w_idm;

    assign w_idm = 16'((32'd1 << ID_BITS) - 32'd1);
    always_comb begin
        w_now = {16'd0, i_now} & TMask;
        w_c.op    = i_operation;
        w_c.job   = i_job_id & w_idm;
        w_c.grp   = i_group_id & w_idm;
        w_c.delay = i_delay;
        w_c.now   = w_now;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) r_q[r_wp] <= w_c;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_valid && o_ready) r_wp <= ~r_wp;
            if (o_cmd_valid && i_cmd_ready) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_valid && o_ready) - 2'(o_cmd_valid && i_cmd_ready);
        end
    end

endmodule

// ----- hw/rtl/dtq_back.sv -----
module dtq_back
    import dtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDef,
    parameter int TIME_BITS   = TimeBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    output logic        o_cmd_ready,
    input  t_cmd        i_cmd,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [15:0] o_out_job_id,
    output logic [15:0] o_out_group_id,
    output logic [1:0]  o_timer_action,
    output logic [31:0] o_timer_value,
    output logic        o_last
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [63:0] TMask = (TIME_BITS >= 64) ? '1 : ((64'd1 << TIME_BITS) - 64'd1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;   // sweep entries one a cycle
    localparam logic [2:0] S_ACT  = 3'd2;   // apply result of sweep
    localparam logic [2:0] S_EMIT = 3'd3;   // wait for result beat to drain
    localparam logic [2:0] S_POST = 3'd4;   // apply result of second sweep (new earliest)

    logic [2:0]  r_st;
    t_cmd        r_cmd;
    logic [QUEUE_DEPTH-1:0] r_vld;
    logic [63:0] r_dl  [QUEUE_DEPTH];
    logic [15:0] r_job [QUEUE_DEPTH];
    logic [15:0] r_grp [QUEUE_DEPTH];
    logic [31:0] r_ord [QUEUE_DEPTH];
    logic [31:0] r_ins;
    logic [IW-1:0] r_idx;
    logic [CW-1:0] r_cnt;   // released so far

    // sweep results
    logic          r_bf;         // best (earliest) found
    logic [IW-1:0] r_bi;
    logic [63:0]   r_bdl;
    logic [31:0]   r_bage;
    logic          r_pf;         // cancel-by-id pick
    logic [IW-1:0] r_pi;
    logic [31:0]   r_page;
    logic          r_ff;         // free slot
    logic [IW-1:0] r_fi;
    logic [63:0]   r_old;
    logic          r_oldv;
    logic          r_post;       // in post sweep

    logic          r_ov;
    logic [2:0]    r_okind;
    logic [15:0]   r_oj, r_og;
    logic [1:0]    r_oa;
    logic [31:0]   r_otv;
    logic          r_ol;

    logic [31:0] w_age;
    logic        w_better;
    logic [64:0] w_sum;
    logic [63:0] w_dl;
    logic [63:0] w_diff;
    logic [31:0] w_tk;
    logic        w_last_idx;

    assign w_age  = r_ins - r_ord[r_idx];
    assign w_better = !r_bf || (r_dl[r_idx] < r_bdl) ||
                      ((r_dl[r_idx] == r_bdl) && (w_age > r_bage));
    assign w_sum  = {1'b0, r_cmd.now} + {33'd0, r_cmd.delay};
    assign w_dl   = (w_sum[64] || (w_sum[63:0] > TMask)) ? TMask : w_sum[63:0];
    assign w_diff = r_bdl - r_cmd.now;
    assign w_tk   = (r_bdl <= r_cmd.now) ? 32'd0 :
                    ((w_diff > {32'd0, TimerMax}) ? TimerMax : w_diff[31:0]);
    assign w_last_idx = (r_idx == IW'(QUEUE_DEPTH - 1));

    assign o_cmd_ready    = (r_st == S_IDLE) && !r_ov;
    assign o_valid        = r_ov;
    assign o_kind         = r_okind;
    assign o_out_job_id   = r_oj;
    assign o_out_group_id = r_og;
    assign o_timer_action = r_oa;
    assign o_timer_value  = r_otv;
    assign o_last         = r_ol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_vld <= '0;
            r_ins <= '0;
            r_ov  <= 1'b0;
            r_idx <= '0;
            r_cnt <= '0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_cmd_valid && o_cmd_ready) begin
                        r_cmd  <= i_cmd;
                        r_idx  <= '0;
                        r_cnt  <= '0;
                        r_bf   <= 1'b0;
                        r_pf   <= 1'b0;
                        r_ff   <= 1'b0;
                        r_post <= 1'b0;
                        r_st   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_vld[r_idx]) begin
                        if (w_better) begin
                            r_bf <= 1'b1; r_bi <= r_idx;
                            r_bdl <= r_dl[r_idx]; r_bage <= w_age;
                        end
                        if (!r_post && r_job[r_idx] == r_cmd.job &&
                            (!r_pf || w_age < r_page)) begin
                            r_pf <= 1'b1; r_pi <= r_idx; r_page <= w_age;
                        end
                    end else if (!r_ff) begin
                        r_ff <= 1'b1; r_fi <= r_idx;
                    end
                    if (w_last_idx) begin
                        r_idx <= '0;
                        r_st  <= r_post ? S_POST : S_ACT;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_ACT: begin
                    r_okind <= KIND_DONE; r_oj <= '0; r_og <= '0;
                    r_oa <= TA_LEAVE; r_otv <= '0; r_ol <= 1'b1;
                    case (r_cmd.op)
                        OP_SCHEDULE: begin
                            r_oj <= r_cmd.job; r_og <= r_cmd.grp;
                            if (r_cmd.delay == DelayInfinite) begin
                                r_okind <= KIND_REJ_INF;
                            end else if (!r_ff) begin
                                r_okind <= KIND_REJ_FULL;
                            end else begin
                                r_okind <= KIND_SCHEDULED;
                                r_vld[r_fi] <= 1'b1;
                                r_dl[r_fi]  <= w_dl;
                                r_job[r_fi] <= r_cmd.job;
                                r_grp[r_fi] <= r_cmd.grp;
                                r_ord[r_fi] <= r_ins;
                                r_ins <= r_ins + 32'd1;
                                if (!r_bf || r_bdl > w_dl) begin
                                    r_oa <= TA_RESTART; r_otv <= r_cmd.delay;
                                end
                            end
                            r_ov <= 1'b1; r_st <= S_EMIT;
                        end
                        OP_CANCEL_ID, OP_CANCEL_GRP: begin
                            r_oldv <= r_bf; r_old <= r_bdl;
                            if (r_cmd.op == OP_CANCEL_ID) begin
                                if (r_pf) r_vld[r_pi] <= 1'b0;
                            end else begin
                                for (int i = 0; i < QUEUE_DEPTH; i++)
                                    if (r_grp[i] == r_cmd.grp) r_vld[i] <= 1'b0;
                            end
                            r_bf <= 1'b0; r_post <= 1'b1; r_st <= S_SCAN;
                        end
                        OP_CANCEL_ALL: begin
                            r_vld <= '0; r_oa <= TA_STOP;
                            r_ov <= 1'b1; r_st <= S_EMIT;
                        end
                        OP_ALARM: begin
                            if (r_bf && r_bdl <= r_cmd.now &&
                                32'(r_cnt) < 32'(ReleaseLimit)) begin
                                r_okind <= KIND_RELEASED;
                                r_oj <= r_job[r_bi]; r_og <= r_grp[r_bi];
                                r_ol <= 1'b0;
                                r_vld[r_bi] <= 1'b0;
                                r_cnt <= r_cnt + CW'(1);
                            end else if (r_bf) begin
                                r_oa <= TA_RESTART; r_otv <= w_tk;
                            end
                            r_ov <= 1'b1; r_st <= S_EMIT;
                        end
                        default: begin
                            r_ov <= 1'b1; r_st <= S_EMIT;
                        end
                    endcase
                end
                S_POST: begin
                    r_okind <= KIND_DONE; r_oj <= '0; r_og <= '0;
                    r_ol <= 1'b1; r_oa <= TA_LEAVE; r_otv <= '0;
                    if (r_oldv && r_bf && r_bdl != r_old) begin
                        r_oa <= TA_RESTART; r_otv <= w_tk;
                    end
                    r_ov <= 1'b1; r_st <= S_EMIT;
                end
                S_EMIT: begin
                    // hold until the beat has gone, then rescan if alarm continues
                    if (!r_ov || i_ready) begin
                        if (!r_ol) begin
                            r_bf <= 1'b0; r_idx <= '0; r_st <= S_SCAN;
                        end else begin
                            r_st <= S_IDLE;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

endmodule
